// ===== sv/frustum_cull_test_assert.svh =====
// Assertion macros shared by the frustum cull test modules.
// Depends on the using module having ports aclk and aresetn.
`ifndef FRUSTUM_CULL_TEST_ASSERT_SVH
`define FRUSTUM_CULL_TEST_ASSERT_SVH

// Checked on every rising edge of aclk, switched off while reset is asserted.
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define FCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== sv/fct_pkg.sv =====
// Shared types and constants for the frustum cull test block.
// No dependencies.
`timescale 1ns / 1ps

package fct_pkg;

    localparam int FCT_PLANE_COUNT = 6;
    localparam int FCT_COORD_WIDTH = 16;
    localparam int FCT_CFG_W       = 64;
    localparam int FCT_CFG_INDEX_W = 3;
    localparam int FCT_PLANE_IDX_W = 3;

    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_BOX    = 2'd1;
    localparam logic [1:0] MODE_SPHERE = 2'd2;

    // Control that travels with an item from cell to cell.
    typedef struct packed {
        logic                       valid;
        logic [1:0]                 mode;
        logic                       found;
        logic [FCT_PLANE_IDX_W-1:0] idx;
    } fct_ctl_t;

endpackage

// ===== sv/fct_cell.sv =====
// One plane cell of the frustum cull chain: holds one plane register and tests
// each passing item against it in two stages. Depends on fct_pkg.
`timescale 1ns / 1ps
`include "frustum_cull_test_assert.svh"

module fct_cell import fct_pkg::*; #(
    parameter int COORD_WIDTH = FCT_COORD_WIDTH,
    parameter int CELL_INDEX  = 0,
    parameter int PAY_W       = 7 * FCT_COORD_WIDTH - 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       cfg_wr_en,
    input  logic [FCT_CFG_INDEX_W-1:0] cfg_index,
    input  logic [FCT_CFG_W-1:0]       cfg_wdata,
    input  fct_ctl_t                   ctl_in,
    input  logic [PAY_W-1:0]           pay_in,
    output fct_ctl_t                   ctl_out,
    output logic [PAY_W-1:0]           pay_out
);

    localparam int W      = COORD_WIDTH;
    localparam int PROD_W = W + 16;
    localparam int SUM_W  = (W + 18 > 32) ? W + 18 : 32;
    localparam logic [FCT_CFG_INDEX_W-1:0] MY_CFG = FCT_CFG_INDEX_W'(CELL_INDEX);
    localparam logic [FCT_PLANE_IDX_W-1:0] MY_IDX = FCT_PLANE_IDX_W'(CELL_INDEX);

    logic [FCT_CFG_W-1:0] plane_reg;

    logic signed [15:0] nx, ny, nz, dd;
    logic signed [W-1:0] px, py, pz, qx, qy, qz;
    logic [W-2:0] rad;
    logic signed [W-1:0] cx, cy, cz;
    logic is_box;

    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [SUM_W-1:0]  off_next, off_reg;
    logic signed [SUM_W-1:0]  sum;
    fct_ctl_t                 ctl_a_reg, ctl_b_reg, ctl_b_next;
    logic [PAY_W-1:0]         pay_a_reg, pay_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (cfg_wr_en && cfg_index == MY_CFG) begin
            plane_reg <= cfg_wdata;
        end
    end

    assign nx = plane_reg[15:0];
    assign ny = plane_reg[31:16];
    assign nz = plane_reg[47:32];
    assign dd = plane_reg[63:48];

    assign px  = pay_in[W-1:0];
    assign py  = pay_in[2*W-1:W];
    assign pz  = pay_in[3*W-1:2*W];
    assign qx  = pay_in[4*W-1:3*W];
    assign qy  = pay_in[5*W-1:4*W];
    assign qz  = pay_in[6*W-1:5*W];
    assign rad = pay_in[7*W-2:6*W];

    // Box mode picks the positive vertex: max corner where the normal is not negative.
    assign is_box = (ctl_in.mode == MODE_BOX);
    assign cx = (is_box && !nx[15]) ? qx : px;
    assign cy = (is_box && !ny[15]) ? qy : py;
    assign cz = (is_box && !nz[15]) ? qz : pz;

    always_comb begin
        prod_x_next = PROD_W'(nx) * PROD_W'(cx);
        prod_y_next = PROD_W'(ny) * PROD_W'(cy);
        prod_z_next = PROD_W'(nz) * PROD_W'(cz);
        // The sphere test s < -r is folded into s + r < 0.
        off_next = SUM_W'(dd) <<< 14;
        if (ctl_in.mode == MODE_SPHERE) begin
            off_next = off_next + (SUM_W'(rad) <<< 14);
        end
    end

    always_comb begin
        sum = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg) + off_reg;
        ctl_b_next = ctl_a_reg;
        if (ctl_a_reg.valid && !ctl_a_reg.found && sum[SUM_W-1]) begin
            ctl_b_next.found = 1'b1;
            ctl_b_next.idx   = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            off_reg    <= off_next;
            pay_a_reg  <= pay_in;
            pay_b_reg  <= pay_a_reg;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign pay_out = pay_b_reg;

    `FCT_ASSERT(a_idx_bound, ctl_b_reg.found |-> ctl_b_reg.idx <= MY_IDX, "reject index past cell")
    `FCT_ASSERT(a_found_kept, en && ctl_a_reg.found |=> ctl_b_reg.found, "earlier reject lost")
    `FCT_ASSERT(a_bubble_clean, !ctl_b_reg.valid |-> !ctl_b_reg.found, "empty slot marked")

endmodule

// ===== sv/frustum_cull_test.sv =====
// Frustum cull test block.
//
// Input beats (s_valid/s_ready) carry a mode (point, box or sphere), a point or
// box minimum or sphere center (s_px/s_py/s_pz), a box maximum (s_qx/s_qy/s_qz)
// and a sphere radius. Each beat is tested against PLANE_COUNT planes held in
// the cells of a chain, one plane per cell, written through cfg_wr_en,
// cfg_index and cfg_wdata. The result beat (m_valid/m_ready) gives m_inside_res
// and the lowest rejecting plane in m_reject_plane, PLANE_COUNT when none does.
//
// Each cell registers the products, then the sum and compare result; the
// output register behind the last cell holds the result beat.
// One beat is taken every cycle while the chain is not held; results leave in input order.
// When the receiver holds m_ready low with a result waiting, the whole chain
// holds and s_ready drops in the same cycle; it returns with m_ready.
// Reset clears all plane registers to zero (no plane rejects anything) and
// empties the chain.
// Depends on fct_pkg and fct_cell.
`timescale 1ns / 1ps
`include "frustum_cull_test_assert.svh"

module frustum_cull_test import fct_pkg::*; #(
    parameter int PLANE_COUNT = FCT_PLANE_COUNT,
    parameter int COORD_WIDTH = FCT_COORD_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [FCT_CFG_INDEX_W-1:0]        cfg_index,
    input  logic [FCT_CFG_W-1:0]              cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_mode,
    input  logic signed [COORD_WIDTH-1:0]     s_px,
    input  logic signed [COORD_WIDTH-1:0]     s_py,
    input  logic signed [COORD_WIDTH-1:0]     s_pz,
    input  logic signed [COORD_WIDTH-1:0]     s_qx,
    input  logic signed [COORD_WIDTH-1:0]     s_qy,
    input  logic signed [COORD_WIDTH-1:0]     s_qz,
    input  logic [COORD_WIDTH-2:0]            s_radius,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_inside_res,
    output logic [FCT_PLANE_IDX_W-1:0]        m_reject_plane
);

    localparam int PAY_W = 7 * COORD_WIDTH - 1;
    localparam logic [FCT_PLANE_IDX_W-1:0] PLANE_NONE = FCT_PLANE_IDX_W'(PLANE_COUNT);

    fct_ctl_t         ctl_chain [0:PLANE_COUNT];
    logic [PAY_W-1:0] pay_chain [0:PLANE_COUNT];
    logic             en;

    logic                       out_valid_reg;
    logic                       inside_reg;
    logic [FCT_PLANE_IDX_W-1:0] plane_idx_reg;

    // The chain moves whenever the output register is free or being emptied.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        ctl_chain[0]       = '0;
        ctl_chain[0].valid = s_valid;
        ctl_chain[0].mode  = s_mode;
        pay_chain[0]       = {s_radius, s_qz, s_qy, s_qx, s_pz, s_py, s_px};
    end

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        fct_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .CELL_INDEX  (i),
            .PAY_W       (PAY_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .cfg_wr_en (cfg_wr_en),
            .cfg_index (cfg_index),
            .cfg_wdata (cfg_wdata),
            .ctl_in    (ctl_chain[i]),
            .pay_in    (pay_chain[i]),
            .ctl_out   (ctl_chain[i+1]),
            .pay_out   (pay_chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= ctl_chain[PLANE_COUNT].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg    <= !ctl_chain[PLANE_COUNT].found;
            plane_idx_reg <= ctl_chain[PLANE_COUNT].found ? ctl_chain[PLANE_COUNT].idx
                                                          : PLANE_NONE;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_inside_res   = inside_reg;
    assign m_reject_plane = plane_idx_reg;

    `FCT_ASSERT(a_inside_code,
        m_valid |-> (PLANE_COUNT == 8) || (m_inside_res == (m_reject_plane == PLANE_NONE)),
        "inside flag disagrees with plane code")
    `FCT_ASSERT(a_chain_hold, !en |=> $stable(ctl_chain[PLANE_COUNT]), "chain moved during stall")
    `FCT_ASSERT(a_ready_free, !m_valid |-> s_ready, "input blocked with output empty")

endmodule
